/* rtl/core/cci_pkg.sv */
// shared types, constants and the arctangent table of the circle overlap block
// no dependencies
package cci_pkg;

  localparam int unsigned CORDIC_ITERATIONS_DEF = 24;
  localparam int unsigned ANGLE_LAT_BASE = 69;
  localparam int unsigned DIV_STEPS = 30;
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [60:0] ONE_SQ_Q60 = 61'h1000_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_B_IN_A = 2'd1,
    KIND_A_IN_B = 2'd2,
    KIND_PARTIAL = 2'd3
  } cci_kind_t;

  typedef struct packed {
    logic [19:0] radius_a;
    logic [19:0] radius_b;
    logic [20:0] centre_distance;
  } cci_in_t;

  typedef struct packed {
    logic [35:0] overlap_area;
    logic [1:0] overlap_case;
  } cci_out_t;

  typedef struct packed {
    logic clamp;
    logic neg;
    logic [31:0] mag;
    logic [31:0] den;
  } cci_ang_t;

  typedef struct packed {
    cci_kind_t kind;
    logic [39:0] sqa;
    logic [39:0] sqb;
    cci_ang_t ang_a;
    cci_ang_t ang_b;
  } cci_item_t;

  typedef struct packed {
    cci_kind_t kind;
    logic [39:0] sqa;
    logic [39:0] sqb;
  } cci_meta_t;

  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;
      1: v = 32'h1DAC6705;
      2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;
      4: v = 32'h03FEAB76;
      5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;
      7: v = 32'h007FFF55;
      8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/cci_fifo.sv */
// small register queue with full and empty flags
// no dependencies
module cci_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop = pop & ~empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end
endmodule

/* rtl/core/cci_front.sv */
// front part: squares, case classification and cosine ratio set-up
// depends on cci_pkg
module cci_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  cci_pkg::cci_in_t   in_data,
  output logic               in_full,
  output logic               q_push,
  output cci_pkg::cci_item_t q_data,
  input  logic               q_full
);
  import cci_pkg::*;

  logic s1_v_r, s2_v_r, f_en;
  logic [19:0] ra_r, rb_r;
  logic [20:0] d_r;
  logic [39:0] sqa_r, sqb_r;
  logic [41:0] sqd_r;
  logic [40:0] pad_r, pbd_r;
  cci_item_t item_r, item_nxt;
  logic [20:0] rsum;
  logic [19:0] diff;

  function automatic cci_ang_t ratio(input logic [39:0] sq_own, input logic [39:0] sq_oth,
                                     input logic [41:0] sq_d, input logic [40:0] prod);
    logic signed [43:0] num;
    logic [42:0] mag, ms;
    logic [41:0] den, ds;
    logic [3:0] k;
    cci_ang_t r;
    num = $signed({4'b0, sq_own}) + $signed({2'b0, sq_d}) - $signed({4'b0, sq_oth});
    mag = num[43] ? 43'(-num) : num[42:0];
    den = {prod, 1'b0};
    k = '0;
    for (int b = 32; b < 42; b++) begin
      if (den[b]) begin
        k = 4'(b - 31);
      end
    end
    ms = mag >> k;
    ds = den >> k;
    r.neg = num[43];
    r.den = ds[31:0];
    r.clamp = (ds == '0) || (ms >= {1'b0, ds});
    r.mag = r.clamp ? '0 : ms[31:0];
    return r;
  endfunction

  assign f_en = ~(s2_v_r & q_full);
  assign in_full = ~f_en;
  assign q_push = s2_v_r & f_en;
  assign q_data = item_r;

  assign rsum = {1'b0, ra_r} + {1'b0, rb_r};
  assign diff = (ra_r >= rb_r) ? ra_r - rb_r : rb_r - ra_r;

  always_comb begin
    item_nxt.sqa = sqa_r;
    item_nxt.sqb = sqb_r;
    item_nxt.ang_a = ratio(sqa_r, sqb_r, sqd_r, pad_r);
    item_nxt.ang_b = ratio(sqb_r, sqa_r, sqd_r, pbd_r);
    if (ra_r == '0 || rb_r == '0 || d_r > rsum) begin
      item_nxt.kind = KIND_NONE;
    end else if (d_r <= {1'b0, diff} && ra_r >= rb_r) begin
      item_nxt.kind = KIND_B_IN_A;
    end else if (d_r <= {1'b0, diff}) begin
      item_nxt.kind = KIND_A_IN_B;
    end else begin
      item_nxt.kind = KIND_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (f_en) begin
      s1_v_r <= in_push;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      ra_r <= in_data.radius_a;
      rb_r <= in_data.radius_b;
      d_r <= in_data.centre_distance;
      sqa_r <= in_data.radius_a * in_data.radius_a;
      sqb_r <= in_data.radius_b * in_data.radius_b;
      sqd_r <= in_data.centre_distance * in_data.centre_distance;
      pad_r <= in_data.radius_a * in_data.centre_distance;
      pbd_r <= in_data.radius_b * in_data.centre_distance;
      item_r <= item_nxt;
    end
  end
endmodule

/* rtl/core/cci_angle.sv */
// half-angle and segment factor pipeline: divider, square root, two cordic chains
// depends on cci_pkg
module cci_angle #(
  parameter int unsigned CORDIC_ITERATIONS = cci_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  cci_pkg::cci_ang_t ang,
  output logic [31:0]       factor
);
  import cci_pkg::*;

  localparam int unsigned N = CORDIC_ITERATIONS;

  // divider
  logic [31:0] dv_rem_r [DIV_STEPS+1];
  logic [29:0] dv_q_r [DIV_STEPS+1];
  logic [31:0] dv_den_r [DIV_STEPS+1];
  logic dv_neg_r [DIV_STEPS+1];
  logic dv_clp_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= ang.clamp ? '0 : ang.mag;
      dv_q_r[0] <= '0;
      dv_den_r[0] <= ang.den;
      dv_neg_r[0] <= ang.neg;
      dv_clp_r[0] <= ang.clamp;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [32:0] rem2;
    logic ge;
    assign rem2 = {dv_rem_r[j], 1'b0};
    assign ge = rem2 >= {1'b0, dv_den_r[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j+1] <= ge ? 32'(rem2 - {1'b0, dv_den_r[j]}) : rem2[31:0];
        dv_q_r[j+1] <= {dv_q_r[j][28:0], ge};
        dv_den_r[j+1] <= dv_den_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
        dv_clp_r[j+1] <= dv_clp_r[j];
      end
    end
  end

  // cosine magnitude and 1 - c^2
  logic [30:0] cm_r, cm2_r;
  logic neg_r, neg2_r;
  logic [60:0] sq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r <= dv_clp_r[DIV_STEPS] ? ONE_Q30 : {1'b0, dv_q_r[DIV_STEPS]};
      neg_r <= dv_neg_r[DIV_STEPS];
      sq_r <= ONE_SQ_Q60 - ({30'b0, cm_r} * {30'b0, cm_r});
      cm2_r <= cm_r;
      neg2_r <= neg_r;
    end
  end

  // square root, two radicand bits a step
  logic [61:0] sr_v_r [SQRT_STEPS+1];
  logic [32:0] sr_rem_r [SQRT_STEPS+1];
  logic [30:0] sr_res_r [SQRT_STEPS+1];
  logic [30:0] sr_cm_r [SQRT_STEPS+1];
  logic sr_neg_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_v_r[0] <= {1'b0, sq_r};
      sr_rem_r[0] <= '0;
      sr_res_r[0] <= '0;
      sr_cm_r[0] <= cm2_r;
      sr_neg_r[0] <= neg2_r;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [34:0] rem_w, trial;
    logic ge;
    assign rem_w = {sr_rem_r[k], sr_v_r[k][61-2*k -: 2]};
    assign trial = {2'b0, sr_res_r[k], 2'b01};
    assign ge = rem_w >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem_r[k+1] <= ge ? 33'(rem_w - trial) : rem_w[32:0];
        sr_res_r[k+1] <= {sr_res_r[k][29:0], ge};
        sr_v_r[k+1] <= sr_v_r[k];
        sr_cm_r[k+1] <= sr_cm_r[k];
        sr_neg_r[k+1] <= sr_neg_r[k];
      end
    end
  end

  // vectoring cordic
  logic signed [33:0] vx_r [N+1];
  logic signed [33:0] vy_r [N+1];
  logic signed [33:0] vz_r [N+1];
  logic swap;
  logic [30:0] s_w, c_w;

  assign s_w = sr_res_r[SQRT_STEPS];
  assign c_w = sr_cm_r[SQRT_STEPS];
  assign swap = sr_neg_r[SQRT_STEPS] && (c_w != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (swap) begin
        vx_r[0] <= $signed({3'b0, s_w});
        vy_r[0] <= $signed({3'b0, c_w});
        vz_r[0] <= $signed({2'b0, HALF_PI_Q30});
      end else begin
        vx_r[0] <= sr_neg_r[SQRT_STEPS] ? -$signed({3'b0, c_w}) : $signed({3'b0, c_w});
        vy_r[0] <= $signed({3'b0, s_w});
        vz_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [33:0] dx, dy, at;
    assign dx = vy_r[i] >>> i;
    assign dy = vx_r[i] >>> i;
    assign at = $signed({2'b0, atan_entry(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_r[i][33]) begin
          vx_r[i+1] <= vx_r[i] + dx;
          vy_r[i+1] <= vy_r[i] - dy;
          vz_r[i+1] <= vz_r[i] + at;
        end else begin
          vx_r[i+1] <= vx_r[i] - dx;
          vy_r[i+1] <= vy_r[i] + dy;
          vz_r[i+1] <= vz_r[i] - at;
        end
      end
    end
  end

  // rotation cordic
  logic signed [33:0] rx_r [N+1];
  logic signed [33:0] ry_r [N+1];
  logic signed [33:0] rz_r [N+1];
  logic [31:0] ra_r [N+1];
  logic [31:0] a_w;

  always_comb begin
    if (vz_r[N][33]) begin
      a_w = '0;
    end else if (vz_r[N] > $signed({2'b0, PI_Q30})) begin
      a_w = PI_Q30;
    end else begin
      a_w = vz_r[N][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r[0] <= a_w;
      rx_r[0] <= $signed({2'b0, GAIN_Q30});
      ry_r[0] <= '0;
      rz_r[0] <= $signed({2'b0, a_w}) - $signed({2'b0, HALF_PI_Q30});
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [33:0] dx, dy, at;
    assign dx = ry_r[i] >>> i;
    assign dy = rx_r[i] >>> i;
    assign at = $signed({2'b0, atan_entry(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        ra_r[i+1] <= ra_r[i];
        if (!rz_r[i][33]) begin
          rx_r[i+1] <= rx_r[i] - dx;
          ry_r[i+1] <= ry_r[i] + dy;
          rz_r[i+1] <= rz_r[i] - at;
        end else begin
          rx_r[i+1] <= rx_r[i] + dx;
          ry_r[i+1] <= ry_r[i] - dy;
          rz_r[i+1] <= rz_r[i] + at;
        end
      end
    end
  end

  // a + sin a * (-cos a)
  logic signed [63:0] p_r;
  logic [31:0] pa_r, f_r;
  logic signed [35:0] fs;

  assign fs = $signed({4'b0, pa_r}) + 36'(p_r >>> 30);
  assign factor = f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= $signed(rx_r[N][31:0]) * $signed(ry_r[N][31:0]);
      pa_r <= ra_r[N];
      if (fs[35]) begin
        f_r <= '0;
      end else if (fs[34:32] != '0) begin
        f_r <= '1;
      end else begin
        f_r <= fs[31:0];
      end
    end
  end
endmodule

/* rtl/core/cci_back.sv */
// back part: two angle pipelines, matching side line, area scaling and output stage
// depends on cci_pkg, cci_angle
module cci_back #(
  parameter int unsigned CORDIC_ITERATIONS = cci_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cci_pkg::cci_item_t q_data,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               o_push,
  output cci_pkg::cci_out_t  o_data,
  input  logic               o_full
);
  import cci_pkg::*;

  localparam int unsigned LAT = ANGLE_LAT_BASE + 2 * CORDIC_ITERATIONS;

  logic en;
  logic [31:0] fa, fb;
  logic ln_v_r [LAT];
  cci_meta_t ln_m_r [LAT];
  logic sc_v_r, fin_v_r;
  cci_kind_t sc_k_r;
  logic [51:0] ah_r, al_r, bh_r, bl_r;
  logic [39:0] r2a, r2b;
  logic [31:0] fa_s;
  logic [52:0] suma, sumb;
  logic [34:0] area_a, area_b;
  cci_out_t fin_r, fin_nxt;
  cci_meta_t m_tail;

  assign en = ~(fin_v_r & o_full);
  assign q_pop = en & ~q_empty;
  assign o_push = en & fin_v_r;
  assign o_data = fin_r;

  cci_angle #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ang_a (
    .clk(clk), .en(en), .ang(q_data.ang_a), .factor(fa)
  );

  cci_angle #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ang_b (
    .clk(clk), .en(en), .ang(q_data.ang_b), .factor(fb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        ln_v_r[i] <= 1'b0;
      end
      sc_v_r <= 1'b0;
      fin_v_r <= 1'b0;
    end else if (en) begin
      ln_v_r[0] <= ~q_empty;
      for (int i = 1; i < LAT; i++) begin
        ln_v_r[i] <= ln_v_r[i-1];
      end
      sc_v_r <= ln_v_r[LAT-1];
      fin_v_r <= sc_v_r;
    end
  end

  assign m_tail = ln_m_r[LAT-1];

  always_comb begin
    unique case (m_tail.kind)
      KIND_B_IN_A: begin
        r2a = m_tail.sqb;
        fa_s = PI_Q30;
      end
      KIND_A_IN_B, KIND_NONE: begin
        r2a = m_tail.sqa;
        fa_s = PI_Q30;
      end
      default: begin
        r2a = m_tail.sqa;
        fa_s = fa;
      end
    endcase
    r2b = m_tail.sqb;
  end

  assign suma = {1'b0, ah_r} + {21'b0, al_r[51:20]};
  assign sumb = {1'b0, bh_r} + {21'b0, bl_r[51:20]};
  assign area_a = suma[52:18];
  assign area_b = sumb[52:18];

  always_comb begin
    fin_nxt.overlap_case = sc_k_r;
    unique case (sc_k_r)
      KIND_NONE: fin_nxt.overlap_area = '0;
      KIND_PARTIAL: fin_nxt.overlap_area = {1'b0, area_a} + {1'b0, area_b};
      default: fin_nxt.overlap_area = {1'b0, area_a};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_m_r[0] <= '{kind: q_data.kind, sqa: q_data.sqa, sqb: q_data.sqb};
      for (int i = 1; i < LAT; i++) begin
        ln_m_r[i] <= ln_m_r[i-1];
      end
      sc_k_r <= m_tail.kind;
      ah_r <= r2a[39:20] * fa_s;
      al_r <= r2a[19:0] * fa_s;
      bh_r <= r2b[39:20] * fb;
      bl_r <= r2b[19:0] * fb;
      fin_r <= fin_nxt;
    end
  end
endmodule

/* rtl/core/circle_circle_intersection_area.sv */
// Circle overlap area engine, queue-style request and result channels.
// A request carries two radii (Q12.8) and the centre distance (Q13.8) as one
// packed struct; it is taken at a clock edge with in_push high and in_full low.
// Each request yields exactly one result (area Q28.8 and case code), in order;
// the oldest result sits on out_data while out_empty is low and leaves on an
// edge with out_pop high.
// Throughput: one request per cycle while in_full is low; the latency is set
// by the 30-step divider, the 31-step square root and the two cordic chains
// of the back pipeline.
// A four-entry queue sits between the classifying front and the back
// pipeline, and a four-entry result queue at the output; when the receiver
// stops popping, the back pipeline holds, the middle queue fills and in_full
// rises. Synchronous active-low reset empties both queues and all stage valids;
// no state survives between requests.
// depends on cci_pkg, cci_fifo, cci_front, cci_back
module circle_circle_intersection_area #(
  parameter int unsigned CORDIC_ITERATIONS = cci_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  cci_pkg::cci_in_t  in_data,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output cci_pkg::cci_out_t out_data
);
  import cci_pkg::*;

  logic q_push, q_full, q_pop, q_empty, o_push, o_full;
  cci_item_t q_wdata, q_rdata;
  cci_out_t o_wdata;

  cci_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
  );

  cci_fifo #(.WIDTH($bits(cci_item_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  cci_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_data(q_rdata), .q_empty(q_empty), .q_pop(q_pop),
    .o_push(o_push), .o_data(o_wdata), .o_full(o_full)
  );

  cci_fifo #(.WIDTH($bits(cci_out_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n), .push(o_push), .wdata(o_wdata), .full(o_full),
    .pop(out_pop), .rdata(out_data), .empty(out_empty)
  );
endmodule
